// ----- rtl/core/deque_pkg.sv -----
package deque_pkg;

    // Operation codes carried by a request
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Status codes returned with each result
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // Value returned when nothing was read
    localparam logic signed [31:0] NOT_READ = -32'sd1;

    // Controller states
    typedef enum logic
    {
        S_IDLE,
        S_LOAD
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed
    {
        logic exec;
        logic load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed
    {
        logic out_free;
    } dp_sts_t;

endpackage

// ----- rtl/core/integer_deque_with_indexed_read.sv -----
// Bounded double-ended queue of signed 32-bit values held in a ring memory
// of DEPTH entries, with a front pointer and an element count. Each request
// is one operation (push front, push back, pop front, pop back, read at a
// position from the front, clear) and returns exactly one result: the value
// read or -1, the length after the operation, an empty flag and a status.
// In the accepting cycle a request updates the pointers, writes the ring
// and starts the registered memory read; the controller then waits in its
// load state until the output register is free and moves the result into
// it. The block takes no new request until that result is loaded.
// A new request is accepted while an earlier result waits in the output
// register. The ring needs no clearing after reset; reads only reach
// entries that pushes have written.
module integer_deque_with_indexed_read
#(
    parameter int DEPTH = 64,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] data_value,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [CNT_W-1:0]   length,
    output logic               empty_flag,
    output logic [1:0]         status
);
    import deque_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    deque_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Ring, pointers and output register
    deque_dp
    #(
        .DEPTH (DEPTH),
        .IDX_W ($clog2(DEPTH)),
        .CNT_W (CNT_W)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .data_value (data_value),
        .position   (position),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_value (read_value),
        .length     (length),
        .empty_flag (empty_flag),
        .status     (status)
    );

endmodule

// ----- rtl/core/deque_ctrl.sv -----
module deque_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  deque_pkg::dp_sts_t sts,
    output deque_pkg::dp_cmd_t cmd,
    output logic              in_stall
);
    import deque_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.exec = 1'b0;
        cmd.load = 1'b0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.exec = in_valid;
            end
            S_LOAD:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/core/deque_dp.sv -----
module deque_dp
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  deque_pkg::dp_cmd_t  cmd,
    output deque_pkg::dp_sts_t  sts,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] data_value,
    input  logic [5:0]         position,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] read_value,
    output logic [CNT_W-1:0]   length,
    output logic               empty_flag,
    output logic [1:0]         status
);
    import deque_pkg::*;

    // Sum width for slot arithmetic: front plus an offset below DEPTH
    localparam int SUM_W = ((IDX_W > 6) ? IDX_W : 6) + 1;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_q;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       res_status_reg;
    logic [1:0]       res_status_next;
    logic             res_read_reg;
    logic             res_read_next;

    logic               out_valid_reg;
    logic signed [31:0] read_value_reg;
    logic [CNT_W-1:0]   length_reg;
    logic               empty_reg;
    logic [1:0]         status_reg;

    logic             full;
    logic             empty;
    logic             in_range;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] read_slot;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;

    // Ring wrap of front plus offset, sum stays below twice DEPTH
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] fixed;
        fixed = sum;
        if (sum >= SUM_W'(DEPTH))
        begin
            fixed = sum - SUM_W'(DEPTH);
        end
        return fixed[IDX_W-1:0];
    endfunction

    // Pointer arithmetic
    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        empty     = (count_reg == '0);
        in_range  = (SUM_W'(position) < SUM_W'(count_reg));
        front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
        front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
        back_slot = wrap_slot(SUM_W'(front_reg) + SUM_W'(count_reg));
        read_slot = wrap_slot(SUM_W'(front_reg) + SUM_W'(position));
    end

    // Operation decode
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        wr_en           = 1'b0;
        wr_addr         = back_slot;
        rd_en           = 1'b0;
        if (cmd.exec)
        begin
            res_status_next = ST_OK;
            res_read_next   = 1'b0;
            case (opcode)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        res_status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        res_status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        res_status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (in_range)
                    begin
                        rd_en         = 1'b1;
                        res_read_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
                OP_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    // Ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= data_value;
        end
        if (rd_en)
        begin
            rd_q <= mem[read_slot];
        end
    end

    // Pointers and pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            res_status_reg <= ST_OK;
            res_read_reg   <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_read_reg   <= res_read_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_value_reg <= res_read_reg ? rd_q : NOT_READ;
            length_reg     <= count_reg;
            empty_reg      <= (count_reg == '0);
            status_reg     <= res_status_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign length       = length_reg;
    assign empty_flag   = empty_reg;
    assign status       = status_reg;

endmodule

// ----- rtl/core/deque_chk.sv -----
module deque_chk
#(
    parameter int DEPTH = 64,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] read_value,
    input logic [CNT_W-1:0]   length,
    input logic               empty_flag,
    input logic [1:0]         status
);
    import deque_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(length)
            && $stable(status))
        else $error("stalled result changed");

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted back to back");

    // Length never exceeds capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length <= CNT_W'(DEPTH)))
        else $error("length above capacity");

    // Empty flag tracks the length
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_flag == (length == '0)))
        else $error("empty flag disagrees with length");

    // A failed request never returns data
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (read_value == NOT_READ))
        else $error("data returned on failed request");

endmodule

bind integer_deque_with_indexed_read deque_chk
#(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
)
u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .length     (length),
    .empty_flag (empty_flag),
    .status     (status)
);

// ----- sim/integer_deque_with_indexed_read_tb.sv -----
module integer_deque_with_indexed_read_tb;
    import deque_pkg::*;

    localparam int DEPTH       = 64;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_REQS = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 200;

    // Opcodes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed
    {
        logic signed [31:0] rd;
        logic [LEN_W-1:0]   len;
        logic               empty;
        logic [1:0]         st;
    } deque_result_t;

    typedef struct
    {
        logic [2:0]         op;
        logic signed [31:0] val;
        logic [5:0]         pos;
        bit                 typed;
        deque_result_t      want;
    } stim_row_t;

    typedef enum
    {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } traffic_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         opcode = OP_PUSH_FRONT;
    logic signed [31:0] data_value = '0;
    logic [5:0]         position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] read_value;
    logic [LEN_W-1:0]   length;
    logic               empty_flag;
    logic [1:0]         status;

    // Shadow copy of the ring and its pointers
    logic signed [31:0]         ring_mem [DEPTH];
    logic [$clog2(DEPTH)-1:0]   head_slot = '0;
    logic [LEN_W-1:0]           fill_count = '0;

    deque_result_t pending_results [$];

    int fail_count    = 0;
    int accepted_cnt  = 0;
    int cycle_cnt     = 0;
    int burst_left    = 0;
    int pop_empty_cnt = 0;
    int push_full_cnt = 0;
    int range_cnt     = 0;
    int read_hit_cnt  = 0;
    int peak_len      = 0;

    // Directed requests; rows with typed set carry an expectation written by hand
    localparam int N_DIRECTED = 24;
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_POP_FRONT,  32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_POP_EMPTY}},
        '{OP_POP_BACK,   32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_POP_EMPTY}},
        '{OP_READ,       32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_RANGE}},
        '{OP_SPARE_6,    32'sd5,          6'd1,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_OK}},
        '{OP_SPARE_7,    32'sd7,          6'd2,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_OK}},
        '{OP_CLEAR,      32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_OK}},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF,   6'd0,  1'b1, '{NOT_READ, 7'd1, 1'b0, ST_OK}},
        '{OP_PUSH_FRONT, 32'h8000_0000,   6'd0,  1'b1, '{NOT_READ, 7'd2, 1'b0, ST_OK}},
        '{OP_READ,       32'sd0,          6'd0,  1'b1, '{32'h8000_0000, 7'd2, 1'b0, ST_OK}},
        '{OP_READ,       32'sd0,          6'd1,  1'b1, '{32'h7FFF_FFFF, 7'd2, 1'b0, ST_OK}},
        '{OP_READ,       32'sd0,          6'd2,  1'b1, '{NOT_READ, 7'd2, 1'b0, ST_RANGE}},
        '{OP_READ,       32'sd0,          6'd63, 1'b1, '{NOT_READ, 7'd2, 1'b0, ST_RANGE}},
        '{OP_PUSH_BACK,  32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_PUSH_FRONT, -32'sd1,         6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_READ,       32'sd0,          6'd3,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_POP_BACK,   32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_POP_FRONT,  32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_READ,       32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_POP_FRONT,  32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_POP_BACK,   32'sd0,          6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_POP_FRONT,  32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_POP_EMPTY}},
        '{OP_PUSH_FRONT, 32'h5A5A_5A5A,   6'd0,  1'b0, '{NOT_READ, 7'd0, 1'b0, ST_OK}},
        '{OP_CLEAR,      32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_OK}},
        '{OP_READ,       32'sd0,          6'd0,  1'b1, '{NOT_READ, 7'd0, 1'b1, ST_RANGE}}
    };

    integer_deque_with_indexed_read
    #(
        .DEPTH(DEPTH)
    )
    dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data_value (data_value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .length     (length),
        .empty_flag (empty_flag),
        .status     (status)
    );

    always #5 clk = ~clk;

    // Apply one operation to the shadow deque and return its result
    function automatic deque_result_t apply_deque_op(logic [2:0] op, logic signed [31:0] val,
                                                     logic [5:0] pos);
        deque_result_t res;
        res.rd = NOT_READ;
        res.st = ST_OK;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (fill_count >= DEPTH)
                    res.st = ST_PUSH_FULL;
                else
                begin
                    head_slot = head_slot - 1'b1;
                    ring_mem[head_slot] = val;
                    fill_count++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (fill_count >= DEPTH)
                    res.st = ST_PUSH_FULL;
                else
                begin
                    ring_mem[head_slot + fill_count[$clog2(DEPTH)-1:0]] = val;
                    fill_count++;
                end
            end
            OP_POP_FRONT:
            begin
                if (fill_count == 0)
                    res.st = ST_POP_EMPTY;
                else
                begin
                    head_slot = head_slot + 1'b1;
                    fill_count--;
                end
            end
            OP_POP_BACK:
            begin
                if (fill_count == 0)
                    res.st = ST_POP_EMPTY;
                else
                    fill_count--;
            end
            OP_READ:
            begin
                if (pos >= fill_count)
                    res.st = ST_RANGE;
                else
                    res.rd = ring_mem[head_slot + pos];
            end
            OP_CLEAR:
            begin
                head_slot = '0;
                fill_count = '0;
            end
            default: ;
        endcase
        res.len = fill_count;
        res.empty = (fill_count == 0);
        return res;
    endfunction

    // Offer one request, wait for acceptance, queue its expected result
    task automatic send_request(logic [2:0] op, logic signed [31:0] val, logic [5:0] pos,
                                bit typed, deque_result_t typed_want);
        deque_result_t predicted;
        opcode     <= op;
        data_value <= val;
        position   <= pos;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_deque_op(op, val, pos);
        if (typed)
            predicted = typed_want;
        pending_results.push_back(predicted);
        accepted_cnt++;
        case (predicted.st)
            ST_POP_EMPTY: pop_empty_cnt++;
            ST_PUSH_FULL: push_full_cnt++;
            ST_RANGE:     range_cnt++;
            default:      if (op == OP_READ) read_hit_cnt++;
        endcase
        if (int'(predicted.len) > peak_len)
            peak_len = int'(predicted.len);
    endtask

    // Burst pacing: after a burst, drop valid for a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Main sequence: reset, directed table, random traffic, drain
    initial
    begin
        traffic_mode_t      mode;
        int                 phase_left;
        int                 r;
        logic [2:0]         op;
        logic signed [31:0] val;
        logic [5:0]         pos;
        deque_result_t      no_want;

        no_want = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_request(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pos,
                         directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
        end

        mode = MIX_GROW;
        phase_left = 0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 200);
                case ($urandom_range(0, 2))
                    0:       mode = MIX_GROW;
                    1:       mode = MIX_SHRINK;
                    default: mode = MIX_BALANCED;
                endcase
            end
            phase_left--;

            // Opcode mix depends on the traffic mode
            r = $urandom_range(0, 999);
            if (r < 5)
                op = OP_CLEAR;
            else if (r < 25)
                op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
            else
            begin
                r = r / 10;
                if ((mode == MIX_GROW && r < 75) || (mode == MIX_SHRINK && r < 20) ||
                    (mode == MIX_BALANCED && r < 35))
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if ((mode == MIX_GROW && r < 83) || (mode == MIX_SHRINK && r < 72) ||
                         (mode == MIX_BALANCED && r < 62))
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else
                    op = OP_READ;
            end

            // Occasional extreme values, otherwise full-width random
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h7FFF_FFFF;
                    1:       val = 32'h8000_0000;
                    2:       val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            end
            else
                val = $urandom;

            // Reads mostly land inside the queue
            if (fill_count > 0 && $urandom_range(0, 3) != 0)
                pos = 6'($urandom_range(0, fill_count - 1));
            else
                pos = 6'($urandom_range(0, 63));

            send_request(op, val, pos, 1'b0, no_want);
            pace_sender();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests, peak length %0d, %0d in-range reads", accepted_cnt,
                 peak_len, read_hit_cnt);
        $display("Error cases: %0d pop on empty, %0d push on full, %0d read out of range",
                 pop_empty_cnt, push_full_cnt, range_cnt);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver stall pattern, plus one long hold-off to back the block up
    initial
    begin
        int  run_len;
        int  stall_pct;
        int  held;
        bit  hold_done;

        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && accepted_cnt >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            run_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (run_len)
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {read_value, length, empty_flag, status};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got value %0d length %0d",
                         $time, got.rd, got.len);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: mismatch: expected value %0d length %0d empty %0b ",
                              "status %0d, got value %0d length %0d empty %0b status %0d"},
                             $time, want.rd, want.len, want.empty, want.st,
                             got.rd, got.len, got.empty, got.st);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
